@@ rtl/gpio_port_register_block_defines.svh @@
// Assertion macros shared by the GPIO port register block.
`ifndef GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH
`define GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("GPIO port register block check failed");

// Next-cycle implication, checked outside reset.
`define GPRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("GPIO port register block check failed");

`endif

@@ rtl/gpio_prb_pkg.sv @@
package gpio_prb_pkg;

    localparam int NUM_PINS = 16;

    localparam logic [15:0] PRESENT_MASK = 16'((32'h1 << NUM_PINS) - 32'h1);
    localparam logic [31:0] MODE_RESET   = 32'((64'h1 << (2 * NUM_PINS)) - 64'h1);

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_PIN    = 2'd2;
    localparam logic [1:0] CMD_RESET  = 2'd3;

    localparam logic [1:0] MODE_OUTPUT = 2'b01;

    localparam logic [9:0] ADDR_MODE   = 10'h000;
    localparam logic [9:0] ADDR_OTYPE  = 10'h004;
    localparam logic [9:0] ADDR_SPEED  = 10'h008;
    localparam logic [9:0] ADDR_PULL   = 10'h00c;
    localparam logic [9:0] ADDR_IDR    = 10'h010;
    localparam logic [9:0] ADDR_ODR    = 10'h014;
    localparam logic [9:0] ADDR_BSRR   = 10'h018;
    localparam logic [9:0] ADDR_AFL    = 10'h020;
    localparam logic [9:0] ADDR_AFH    = 10'h024;
    localparam logic [9:0] ADDR_BRR    = 10'h028;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  addr;
        logic [31:0] wdata;
        logic [3:0]  pin;
        logic        level;
    } gpio_prb_req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [15:0] driven_levels;
        logic [15:0] rise_mask;
        logic [15:0] fall_mask;
    } gpio_prb_rsp_t;

endpackage

@@ rtl/gpio_port_register_block.sv @@
// GPIO port register block.
// Request channel (req_valid, req_ready, req): each item is a bus read, a bus
// write, a pin input change or a pulse on the port's reset line.
// Response channel (rsp_valid, rsp_ready, rsp): exactly one item per request,
// in order, carrying read data, the driven pin levels and rise and fall masks.
// An accepted request is held in an input stage register; when the output
// register can advance, the register file is read and updated and the response
// is captured in the output register, from which it is offered on rsp.
// One request is accepted per cycle when the receiver keeps rsp_ready high.
// When the receiver stalls, the output register holds its item and the input
// stage can still take one more request; after that req_ready drops until the
// output register drains.
// After rst_n is released every pin mode reads as all ones, all other
// registers, input levels and driven levels are zero, and both stages are
// empty. A reset-line item with level high restores the registers but keeps
// the input levels, then re-evaluates the driven levels.
`include "gpio_port_register_block_defines.svh"

module gpio_port_register_block (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  gpio_prb_pkg::gpio_prb_req_t req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output gpio_prb_pkg::gpio_prb_rsp_t rsp
);
    import gpio_prb_pkg::*;

    logic          stage_valid_reg;
    gpio_prb_req_t stage_reg;
    logic          out_valid_reg;
    gpio_prb_rsp_t out_reg;

    logic [31:0] pin_modes_reg,     pin_modes_next;
    logic [31:0] output_types_reg,  output_types_next;
    logic [31:0] output_speeds_reg, output_speeds_next;
    logic [31:0] pull_settings_reg, pull_settings_next;
    logic [15:0] input_levels_reg,  input_levels_next;
    logic [31:0] output_data_reg,   output_data_next;
    logic [31:0] alt_func_low_reg,  alt_func_low_next;
    logic [31:0] alt_func_high_reg, alt_func_high_next;
    logic [15:0] driven_state_reg,  driven_state_next;

    logic          advance;
    logic          commit;
    logic          update;
    logic [15:0]   driven_eval;
    gpio_prb_rsp_t rsp_next;

    assign advance   = !out_valid_reg || rsp_ready;
    assign commit    = stage_valid_reg && advance;
    assign req_ready = !stage_valid_reg || advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        pin_modes_next     = pin_modes_reg;
        output_types_next  = output_types_reg;
        output_speeds_next = output_speeds_reg;
        pull_settings_next = pull_settings_reg;
        input_levels_next  = input_levels_reg;
        output_data_next   = output_data_reg;
        alt_func_low_next  = alt_func_low_reg;
        alt_func_high_next = alt_func_high_reg;
        update             = 1'b0;
        rsp_next.rdata     = 32'h0;

        case (stage_reg.cmd)
            CMD_READ:
            begin
                case (stage_reg.addr)
                    ADDR_MODE:  rsp_next.rdata = pin_modes_reg;
                    ADDR_OTYPE: rsp_next.rdata = output_types_reg;
                    ADDR_SPEED: rsp_next.rdata = output_speeds_reg;
                    ADDR_PULL:  rsp_next.rdata = pull_settings_reg;
                    ADDR_IDR:   rsp_next.rdata = 32'(input_levels_reg);
                    ADDR_ODR:   rsp_next.rdata = output_data_reg;
                    ADDR_AFL:   rsp_next.rdata = alt_func_low_reg;
                    ADDR_AFH:   rsp_next.rdata = alt_func_high_reg;
                    default:    rsp_next.rdata = 32'h0;
                endcase
            end
            CMD_WRITE:
            begin
                case (stage_reg.addr)
                    ADDR_MODE:
                    begin
                        pin_modes_next = stage_reg.wdata;
                        update         = 1'b1;
                    end
                    ADDR_OTYPE: output_types_next  = stage_reg.wdata;
                    ADDR_SPEED: output_speeds_next = stage_reg.wdata;
                    ADDR_PULL:  pull_settings_next = stage_reg.wdata;
                    ADDR_ODR:
                    begin
                        output_data_next = stage_reg.wdata;
                        update           = 1'b1;
                    end
                    ADDR_BSRR:
                    begin
                        // Set first, then clear, so a clear bit wins.
                        output_data_next = (output_data_reg
                                            | {16'h0, stage_reg.wdata[15:0]})
                                           & ~{16'h0, stage_reg.wdata[31:16]};
                        update           = 1'b1;
                    end
                    ADDR_AFL: alt_func_low_next  = stage_reg.wdata;
                    ADDR_AFH: alt_func_high_next = stage_reg.wdata;
                    ADDR_BRR:
                    begin
                        output_data_next = output_data_reg
                                           & ~{16'h0, stage_reg.wdata[15:0]};
                        update           = 1'b1;
                    end
                    default:
                    begin
                        update = 1'b0;
                    end
                endcase
            end
            CMD_PIN:
            begin
                if (32'(stage_reg.pin) < NUM_PINS)
                begin
                    input_levels_next[stage_reg.pin] = stage_reg.level;
                end
            end
            CMD_RESET:
            begin
                if (stage_reg.level)
                begin
                    pin_modes_next     = MODE_RESET;
                    output_types_next  = 32'h0;
                    output_speeds_next = 32'h0;
                    pull_settings_next = 32'h0;
                    output_data_next   = 32'h0;
                    alt_func_low_next  = 32'h0;
                    alt_func_high_next = 32'h0;
                    update             = 1'b1;
                end
            end
            default:
            begin
                update = 1'b0;
            end
        endcase

        driven_eval = 16'h0;
        for (int i = 0; i < NUM_PINS; i++)
        begin
            if (pin_modes_next[2 * i +: 2] == MODE_OUTPUT)
            begin
                driven_eval[i] = output_data_next[i];
            end
        end
        driven_eval = driven_eval & PRESENT_MASK;

        if (update)
        begin
            driven_state_next  = driven_eval;
            rsp_next.rise_mask = (driven_state_reg ^ driven_eval) & driven_eval;
            rsp_next.fall_mask = (driven_state_reg ^ driven_eval) & ~driven_eval;
        end
        else
        begin
            driven_state_next  = driven_state_reg;
            rsp_next.rise_mask = 16'h0;
            rsp_next.fall_mask = 16'h0;
        end
        rsp_next.driven_levels = driven_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            pin_modes_reg     <= MODE_RESET;
            output_types_reg  <= 32'h0;
            output_speeds_reg <= 32'h0;
            pull_settings_reg <= 32'h0;
            input_levels_reg  <= 16'h0;
            output_data_reg   <= 32'h0;
            alt_func_low_reg  <= 32'h0;
            alt_func_high_reg <= 32'h0;
            driven_state_reg  <= 16'h0;
        end
        else
        begin
            if (req_ready)
            begin
                stage_valid_reg <= req_valid;
            end
            if (advance)
            begin
                out_valid_reg <= stage_valid_reg;
            end
            if (commit)
            begin
                pin_modes_reg     <= pin_modes_next;
                output_types_reg  <= output_types_next;
                output_speeds_reg <= output_speeds_next;
                pull_settings_reg <= pull_settings_next;
                input_levels_reg  <= input_levels_next;
                output_data_reg   <= output_data_next;
                alt_func_low_reg  <= alt_func_low_next;
                alt_func_high_reg <= alt_func_high_next;
                driven_state_reg  <= driven_state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            stage_reg <= req;
        end
        if (commit)
        begin
            out_reg <= rsp_next;
        end
    end

    // A pin cannot rise and fall in the same item.
    `GPRB_ASSERT_NOW(a_rise_fall_disjoint, clk, rst_n, rsp_valid,
        (rsp.rise_mask & rsp.fall_mask) == 16'h0)
    // A rising pin must be driven high after the item.
    `GPRB_ASSERT_NOW(a_rise_is_driven, clk, rst_n, rsp_valid,
        (rsp.rise_mask & ~rsp.driven_levels) == 16'h0)
    // Reads never change the driven levels.
    `GPRB_ASSERT_NEXT(a_read_keeps_driven, clk, rst_n,
        commit && (stage_reg.cmd == CMD_READ),
        driven_state_reg == $past(driven_state_reg))
    // A stalled item in the input stage is not dropped.
    `GPRB_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid_reg && !advance,
        stage_valid_reg && out_valid_reg)

endmodule

@@ test/tb.sv @@
module tb;
    import gpio_prb_pkg::*;

    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [9:0] MAPPED_ADDRS [10] = '{ADDR_MODE, ADDR_OTYPE, ADDR_SPEED, ADDR_PULL,
        ADDR_IDR, ADDR_ODR, ADDR_BSRR, ADDR_AFL, ADDR_AFH, ADDR_BRR};
    localparam logic [9:0] OUTPUT_ADDRS [4] = '{ADDR_MODE, ADDR_ODR, ADDR_BSRR, ADDR_BRR};

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  addr;
        logic [31:0] wdata;
        logic [3:0]  pin;
        logic        level;
        logic        has_literal;
        logic [31:0] rdata;
        logic [15:0] driven;
        logic [15:0] rise;
        logic [15:0] fall;
    } directed_row_t;

    // Rows with has_literal set carry their expected response; the rest use the predictor.
    localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{CMD_READ,  ADDR_MODE, 32'h0000_0000, 4'd0, 1'b0, 1'b1, 32'hffff_ffff, 16'h0, 16'h0, 16'h0},
    '{CMD_WRITE, ADDR_MODE, 32'h5555_5555, 4'd0, 1'b0, 1'b1, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_WRITE, ADDR_ODR,  32'hffff_ffff, 4'd0, 1'b0, 1'b1, 32'h0, 16'hffff, 16'hffff, 16'h0},
    '{CMD_WRITE, ADDR_BSRR, 32'hffff_0000, 4'd0, 1'b0, 1'b1, 32'h0, 16'h0, 16'h0, 16'hffff},
    '{CMD_WRITE, ADDR_BSRR, 32'hffff_ffff, 4'd0, 1'b0, 1'b1, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_WRITE, ADDR_BSRR, 32'h00ff_ff00, 4'd0, 1'b0, 1'b1, 32'h0, 16'hff00, 16'hff00, 16'h0},
    '{CMD_WRITE, ADDR_BRR,  32'h0000_f0f0, 4'd0, 1'b0, 1'b1, 32'h0, 16'h0f00, 16'h0, 16'hf000},
    '{CMD_WRITE, ADDR_BRR,  32'hffff_0000, 4'd0, 1'b0, 1'b1, 32'h0, 16'h0f00, 16'h0, 16'h0},
    '{CMD_READ,  ADDR_ODR,  32'h0000_0000, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_WRITE, ADDR_MODE, 32'haaaa_aaaa, 4'd0, 1'b0, 1'b1, 32'h0, 16'h0, 16'h0, 16'h0f00},
    '{CMD_WRITE, ADDR_MODE, 32'h0000_0001, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_WRITE, ADDR_ODR,  32'h0000_0001, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_WRITE, ADDR_IDR,  32'hffff_ffff, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_PIN,   ADDR_MODE, 32'h0000_0000, 4'd0, 1'b1, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_PIN,   ADDR_MODE, 32'h0000_0000, 4'd15, 1'b1, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_READ,  ADDR_IDR,  32'h0000_0000, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_WRITE, ADDR_AFH,  32'hffff_ffff, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_READ,  ADDR_AFH,  32'h0000_0000, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_READ,  10'h3ff,   32'h0000_0000, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_READ,  ADDR_BSRR, 32'h0000_0000, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_READ,  ADDR_BRR,  32'h0000_0000, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_WRITE, ADDR_BSRR + 10'd1, 32'hffff_ffff, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_RESET, ADDR_MODE, 32'h0000_0000, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_RESET, ADDR_MODE, 32'h0000_0000, 4'd0, 1'b1, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0},
    '{CMD_READ,  ADDR_MODE, 32'h0000_0000, 4'd0, 1'b0, 1'b1, 32'hffff_ffff, 16'h0, 16'h0, 16'h0},
    '{CMD_READ,  ADDR_IDR,  32'h0000_0000, 4'd0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 16'h0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    gpio_prb_req_t req;
    logic rsp_valid;
    logic rsp_ready;
    gpio_prb_rsp_t rsp;

    logic [31:0] mode_reg;
    logic [31:0] otype_reg;
    logic [31:0] speed_reg;
    logic [31:0] pull_reg;
    logic [31:0] odr_reg;
    logic [31:0] afl_reg;
    logic [31:0] afh_reg;
    logic [15:0] idr_reg;
    logic [15:0] driven_reg;

    gpio_prb_rsp_t pending_responses [$];
    gpio_prb_rsp_t oldest_expected;
    int idle_pct;
    int mismatch_count;
    int response_count;
    int cycle_count;
    int items_by_cmd [4];

    gpio_port_register_block u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function void restore_port_registers();
        mode_reg = MODE_RESET;
        otype_reg = '0;
        speed_reg = '0;
        pull_reg = '0;
        odr_reg = '0;
        afl_reg = '0;
        afh_reg = '0;
    endfunction

    function gpio_prb_rsp_t predict_port_response(input gpio_prb_req_t item);
        gpio_prb_rsp_t result;
        logic refresh;
        logic [15:0] next_driven;
        int pin_idx;
        result = '0;
        refresh = 1'b0;
        case (item.cmd)
            CMD_READ:
            begin
                case (item.addr)
                    ADDR_MODE:  result.rdata = mode_reg;
                    ADDR_OTYPE: result.rdata = otype_reg;
                    ADDR_SPEED: result.rdata = speed_reg;
                    ADDR_PULL:  result.rdata = pull_reg;
                    ADDR_IDR:   result.rdata = {16'h0, idr_reg};
                    ADDR_ODR:   result.rdata = odr_reg;
                    ADDR_AFL:   result.rdata = afl_reg;
                    ADDR_AFH:   result.rdata = afh_reg;
                    default:    result.rdata = '0;
                endcase
            end
            CMD_WRITE:
            begin
                case (item.addr)
                    ADDR_MODE:
                    begin
                        mode_reg = item.wdata;
                        refresh = 1'b1;
                    end
                    ADDR_OTYPE: otype_reg = item.wdata;
                    ADDR_SPEED: speed_reg = item.wdata;
                    ADDR_PULL:  pull_reg = item.wdata;
                    ADDR_ODR:
                    begin
                        odr_reg = item.wdata;
                        refresh = 1'b1;
                    end
                    ADDR_BSRR:
                    begin
                        // Clear wins over set when both halves name a pin.
                        odr_reg[15:0] = (odr_reg[15:0] | item.wdata[15:0]) & ~item.wdata[31:16];
                        refresh = 1'b1;
                    end
                    ADDR_AFL:   afl_reg = item.wdata;
                    ADDR_AFH:   afh_reg = item.wdata;
                    ADDR_BRR:
                    begin
                        odr_reg[15:0] = odr_reg[15:0] & ~item.wdata[15:0];
                        refresh = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_PIN:
            begin
                if (int'(item.pin) < NUM_PINS)
                    idr_reg[item.pin] = item.level;
            end
            default:
            begin
                if (item.level)
                begin
                    restore_port_registers();
                    refresh = 1'b1;
                end
            end
        endcase
        if (refresh)
        begin
            next_driven = '0;
            for (pin_idx = 0; pin_idx < NUM_PINS; pin_idx++)
                if (mode_reg[2 * pin_idx +: 2] == MODE_OUTPUT)
                    next_driven[pin_idx] = odr_reg[pin_idx];
            next_driven = next_driven & PRESENT_MASK;
            result.rise_mask = next_driven & ~driven_reg;
            result.fall_mask = driven_reg & ~next_driven;
            driven_reg = next_driven;
        end
        result.driven_levels = driven_reg;
        return result;
    endfunction

    function gpio_prb_req_t random_port_item();
        gpio_prb_req_t item;
        int roll;
        int pin_idx;
        roll = $urandom_range(99);
        if (roll < 30)
            item.cmd = CMD_READ;
        else if (roll < 78)
            item.cmd = CMD_WRITE;
        else if (roll < 96)
            item.cmd = CMD_PIN;
        else
            item.cmd = CMD_RESET;
        if ($urandom_range(99) < 85)
            item.addr = MAPPED_ADDRS[$urandom_range(9)];
        else
            item.addr = 10'($urandom);
        if (item.cmd == CMD_WRITE && $urandom_range(1) == 1)
            item.addr = OUTPUT_ADDRS[$urandom_range(3)];
        item.wdata = $urandom;
        roll = $urandom_range(19);
        if (roll == 0)
            item.wdata = '0;
        else if (roll == 1)
            item.wdata = '1;
        else if (item.addr == ADDR_MODE && roll < 12)
        begin
            for (pin_idx = 0; pin_idx < 16; pin_idx++)
                item.wdata[2 * pin_idx +: 2] =
                    ($urandom_range(9) < 7) ? MODE_OUTPUT : 2'($urandom);
        end
        item.pin = 4'($urandom);
        item.level = 1'($urandom);
        if (item.cmd == CMD_RESET && $urandom_range(9) < 6)
            item.level = 1'b0;
        return item;
    endfunction

    task automatic send_item(input gpio_prb_req_t item, input logic use_literal,
                             input gpio_prb_rsp_t literal_rsp);
        gpio_prb_rsp_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = predict_port_response(item);
        pending_responses.push_back(use_literal ? literal_rsp : predicted);
        items_by_cmd[item.cmd]++;
    endtask

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH at response %0d, %s: got %h, expected %h",
                 response_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (pending_responses.size() == 0)
                report_mismatch("response with nothing pending", rsp.rdata, 32'h0);
            else
            begin
                oldest_expected = pending_responses.pop_front();
                if (rsp.rdata !== oldest_expected.rdata)
                    report_mismatch("rdata", rsp.rdata, oldest_expected.rdata);
                if (rsp.driven_levels !== oldest_expected.driven_levels)
                    report_mismatch("driven_levels", rsp.driven_levels,
                                    oldest_expected.driven_levels);
                if (rsp.rise_mask !== oldest_expected.rise_mask)
                    report_mismatch("rise_mask", rsp.rise_mask, oldest_expected.rise_mask);
                if (rsp.fall_mask !== oldest_expected.fall_mask)
                    report_mismatch("fall_mask", rsp.fall_mask, oldest_expected.fall_mask);
            end
            response_count++;
        end
        rsp_ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d responses outstanding.",
                     cycle_count, pending_responses.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        gpio_prb_req_t item;
        gpio_prb_rsp_t literal_rsp;
        directed_row_t row;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        idle_pct = 12;
        mismatch_count = 0;
        response_count = 0;
        cycle_count = 0;
        items_by_cmd = '{0, 0, 0, 0};
        restore_port_registers();
        idr_reg = '0;
        driven_reg = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int idx = 0; idx < DIRECTED_ROWS; idx++)
        begin
            row = DIRECTED_TABLE[idx];
            item = '{row.cmd, row.addr, row.wdata, row.pin, row.level};
            literal_rsp = '{row.rdata, row.driven, row.rise, row.fall};
            send_item(item, row.has_literal, literal_rsp);
        end

        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            idle_pct = (idx >= 400 && idx < 650) ? 0 : 12;
            if (idx == 900)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (pending_responses.size() != 0)
                    @(posedge clk);
            end
            send_item(random_port_item(), 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d reads, %0d writes, %0d pin changes, %0d reset-line items.",
                 DIRECTED_ROWS + RANDOM_ITEMS, items_by_cmd[CMD_READ], items_by_cmd[CMD_WRITE],
                 items_by_cmd[CMD_PIN], items_by_cmd[CMD_RESET]);
        $display("Checked %0d responses field by field; %0d field errors.",
                 response_count, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
